@@ rtl/core/rbs_pkg.sv @@
// rbs_pkg: shared types, codes and defaults for the ray / box slab test.
// Used by the channel interfaces, rbs_slab and ray_box_slab_intersect.
`timescale 1ns / 1ps

package rbs_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int COORD_BITS_DEF = 16;

  // configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [31:0]    q_t;
  typedef logic signed [CFG_W-1:0] coord_t;
  // slab time with room for the unbounded ends of an unconstrained axis
  typedef logic signed [32:0]    t_t;

  localparam t_t T_NEG_INF = 33'sh1_0000_0000;
  localparam t_t T_POS_INF = 33'sh0_FFFF_FFFF;

  localparam q_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN = 32'sh8000_0000;

  localparam coord_t BOX_MIN_RST = 16'sd0;
  localparam coord_t BOX_MAX_RST = 16'sd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

endpackage

@@ rtl/core/rbs_ray_if.sv @@
// rbs_ray_if: ray input channel (valid / ready plus the ray fields).
// Depends on rbs_pkg for the Q16.16 field type.
`timescale 1ns / 1ps

interface rbs_ray_if;
  import rbs_pkg::*;

  logic valid;
  logic ready;
  q_t   origin_x;
  q_t   origin_y;
  q_t   origin_z;
  q_t   direction_x;
  q_t   direction_y;
  q_t   direction_z;
  q_t   inverse_x;
  q_t   inverse_y;
  q_t   inverse_z;
  q_t   t_lower;
  q_t   t_upper;

  modport source (
    output valid, origin_x, origin_y, origin_z, direction_x, direction_y, direction_z,
           inverse_x, inverse_y, inverse_z, t_lower, t_upper,
    input  ready
  );

  modport sink (
    input  valid, origin_x, origin_y, origin_z, direction_x, direction_y, direction_z,
           inverse_x, inverse_y, inverse_z, t_lower, t_upper,
    output ready
  );

endinterface

@@ rtl/core/rbs_hit_if.sv @@
// rbs_hit_if: result channel (valid / ready plus hit record fields).
// Depends on rbs_pkg for the Q16.16 field type.
`timescale 1ns / 1ps

interface rbs_hit_if;
  import rbs_pkg::*;

  logic       valid;
  logic       ready;
  logic       hit;
  q_t         t_entry;
  q_t         t_exit;
  logic [1:0] entry_axis;
  logic       entry_on_face;
  logic       entry_negative;
  logic [1:0] exit_axis;
  logic       exit_on_face;
  logic       exit_negative;
  q_t         entry_point_x;
  q_t         entry_point_y;
  q_t         entry_point_z;

  modport source (
    output valid, hit, t_entry, t_exit, entry_axis, entry_on_face, entry_negative,
           exit_axis, exit_on_face, exit_negative, entry_point_x, entry_point_y,
           entry_point_z,
    input  ready
  );

  modport sink (
    input  valid, hit, t_entry, t_exit, entry_axis, entry_on_face, entry_negative,
           exit_axis, exit_on_face, exit_negative, entry_point_x, entry_point_y,
           entry_point_z,
    output ready
  );

endinterface

@@ rtl/core/rbs_slab.sv @@
// rbs_slab: one axis of the slab test, three register stages
// (face offset, product, shift and saturate). Depends on rbs_pkg.
`timescale 1ns / 1ps

module rbs_slab #(
  parameter int FRAC_BITS  = rbs_pkg::FRAC_BITS_DEF,
  parameter int COORD_BITS = rbs_pkg::COORD_BITS_DEF
) (
  input  logic                                       clk,
  input  logic [2:0]                                 adv,
  input  logic signed [COORD_BITS+FRAC_BITS-1:0]     face_lo,
  input  logic signed [COORD_BITS+FRAC_BITS-1:0]     face_hi,
  input  rbs_pkg::q_t                                org,
  input  rbs_pkg::q_t                                dir,
  input  rbs_pkg::q_t                                inv,
  output rbs_pkg::t_t                                t_ent,
  output rbs_pkg::t_t                                t_ext,
  output logic                                       dir_neg
);
  import rbs_pkg::*;

  localparam int FW = COORD_BITS + FRAC_BITS;
  localparam int AW = ((FW > 32) ? FW : 32) + 1;
  localparam int PW = AW + 32;
  localparam int SW = PW - FRAC_BITS;

  // stage a: face minus origin
  logic signed [AW-1:0] ae_r, ax_r;
  q_t                   inv_a_r;
  logic                 neg_a_r, zero_a_r;
  // stage b: products
  logic signed [PW-1:0] pe_r, px_r;
  logic                 neg_b_r, zero_b_r;
  // stage c: saturated times
  t_t                   te_r, tx_r;
  logic                 neg_c_r;

  logic signed [FW-1:0] fe, fx;
  logic                 dneg;
  logic signed [SW-1:0] se, sx;
  t_t                   te_nxt, tx_nxt;

  assign dneg = dir[31];
  assign fe   = dneg ? face_hi : face_lo;
  assign fx   = dneg ? face_lo : face_hi;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ae_r     <= AW'(fe) - AW'(org);
      ax_r     <= AW'(fx) - AW'(org);
      inv_a_r  <= inv;
      neg_a_r  <= dneg;
      zero_a_r <= (dir == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      pe_r     <= ae_r * inv_a_r;
      px_r     <= ax_r * inv_a_r;
      neg_b_r  <= neg_a_r;
      zero_b_r <= zero_a_r;
    end
  end

  // floor division by the fraction scale, then clamp to 32 bits
  assign se = SW'(pe_r >>> FRAC_BITS);
  assign sx = SW'(px_r >>> FRAC_BITS);

  always_comb begin
    if (zero_b_r) begin
      te_nxt = T_NEG_INF;
      tx_nxt = T_POS_INF;
    end else begin
      if ((&se[SW-1:31]) || !(|se[SW-1:31])) begin
        te_nxt = {se[31], se[31:0]};
      end else begin
        te_nxt = se[SW-1] ? t_t'(Q_MIN) : t_t'(Q_MAX);
      end
      if ((&sx[SW-1:31]) || !(|sx[SW-1:31])) begin
        tx_nxt = {sx[31], sx[31:0]};
      end else begin
        tx_nxt = sx[SW-1] ? t_t'(Q_MIN) : t_t'(Q_MAX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      te_r    <= te_nxt;
      tx_r    <= tx_nxt;
      neg_c_r <= neg_b_r;
    end
  end

  assign t_ent   = te_r;
  assign t_ext   = tx_r;
  assign dir_neg = neg_c_r;

endmodule

@@ rtl/core/ray_box_slab_intersect.sv @@
// ray_box_slab_intersect: top level of the fixed-point ray / box slab test.
// Depends on rbs_pkg, rbs_ray_if, rbs_hit_if and rbs_slab.
//
//   port        dir   kind            carries
//   in_ray      in    valid / ready   one ray per beat
//   out_res     out   valid / ready   one hit record per beat
//   cfg_*       in    write strobe    box corner registers, index 0..5
//
// seven register stages lie between a ray's beat on in_ray and its record on out_res.
// one ray per cycle sustained while out_res stays ready; the slab multipliers and the
// entry point multipliers each take one stage, so every stage takes a new ray each cycle.
// rst_n is synchronous; it empties the pipe and loads the default box, corners 0 and 256.
// each stage holds when the one after it is full and stalled, so a stall on
// out_res fills the bubbles before in_ray.ready drops.
`timescale 1ns / 1ps

module ray_box_slab_intersect #(
  parameter int FRAC_BITS  = rbs_pkg::FRAC_BITS_DEF,
  parameter int COORD_BITS = rbs_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbs_pkg::CFG_W-1:0]     cfg_wdata,
  rbs_ray_if.sink                       in_ray,
  rbs_hit_if.source                     out_res
);
  import rbs_pkg::*;

  localparam int NSTG = 7;
  localparam int FW   = COORD_BITS + FRAC_BITS;
  localparam int PW2  = 64 - FRAC_BITS;

  typedef struct packed {
    q_t [2:0] org;
    q_t [2:0] dir;
    q_t       tl;
    q_t       tu;
  } ray_t;

  // ---------------------------------------------------------------- config
  coord_t box_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r[REG_BOX_MIN_X] <= BOX_MIN_RST;
      box_r[REG_BOX_MIN_Y] <= BOX_MIN_RST;
      box_r[REG_BOX_MIN_Z] <= BOX_MIN_RST;
      box_r[REG_BOX_MAX_X] <= BOX_MAX_RST;
      box_r[REG_BOX_MAX_Y] <= BOX_MAX_RST;
      box_r[REG_BOX_MAX_Z] <= BOX_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOX_MIN_X: box_r[REG_BOX_MIN_X] <= cfg_wdata;
        REG_BOX_MIN_Y: box_r[REG_BOX_MIN_Y] <= cfg_wdata;
        REG_BOX_MIN_Z: box_r[REG_BOX_MIN_Z] <= cfg_wdata;
        REG_BOX_MAX_X: box_r[REG_BOX_MAX_X] <= cfg_wdata;
        REG_BOX_MAX_Y: box_r[REG_BOX_MAX_Y] <= cfg_wdata;
        REG_BOX_MAX_Z: box_r[REG_BOX_MAX_Z] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // corner as grid coordinate, then scaled to Q form
  logic [COORD_BITS-1:0]  crd_lo [3];
  logic [COORD_BITS-1:0]  crd_hi [3];
  logic signed [FW-1:0]   face_lo [3];
  logic signed [FW-1:0]   face_hi [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      crd_lo[k]  = COORD_BITS'(box_r[k]);
      crd_hi[k]  = COORD_BITS'(box_r[k+3]);
      face_lo[k] = $signed({crd_lo[k], {FRAC_BITS{1'b0}}});
      face_hi[k] = $signed({crd_hi[k], {FRAC_BITS{1'b0}}});
    end
  end

  // ---------------------------------------------------------- stage control
  logic [NSTG:1] vld_r;
  logic [NSTG:1] adv;

  always_comb begin
    adv[NSTG] = !vld_r[NSTG] || out_res.ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_ray.ready = adv[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[1]) vld_r[1] <= in_ray.valid;
      for (int k = 2; k <= NSTG; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // ray fields travel alongside the slab units
  ray_t ray_in;
  ray_t ray_r [1:6];

  assign ray_in.org = {in_ray.origin_z, in_ray.origin_y, in_ray.origin_x};
  assign ray_in.dir = {in_ray.direction_z, in_ray.direction_y, in_ray.direction_x};
  assign ray_in.tl  = in_ray.t_lower;
  assign ray_in.tu  = in_ray.t_upper;

  always_ff @(posedge clk) begin
    if (adv[1]) ray_r[1] <= ray_in;
    for (int k = 2; k <= 6; k++) begin
      if (adv[k]) ray_r[k] <= ray_r[k-1];
    end
  end

  // ------------------------------------------------- stages 1-3: slab times
  q_t   inv_in [3];
  t_t   te [3];
  t_t   tx [3];
  logic dneg [3];

  assign inv_in[0] = in_ray.inverse_x;
  assign inv_in[1] = in_ray.inverse_y;
  assign inv_in[2] = in_ray.inverse_z;

  for (genvar g = 0; g < 3; g++) begin : g_axis
    rbs_slab #(
      .FRAC_BITS  (FRAC_BITS),
      .COORD_BITS (COORD_BITS)
    ) u_slab (
      .clk     (clk),
      .adv     (adv[3:1]),
      .face_lo (face_lo[g]),
      .face_hi (face_hi[g]),
      .org     (ray_in.org[g]),
      .dir     (ray_in.dir[g]),
      .inv     (inv_in[g]),
      .t_ent   (te[g]),
      .t_ext   (tx[g]),
      .dir_neg (dneg[g])
    );
  end

  // ------------------------------------------------- stage 4: pick entry / exit
  axis_t ea_nxt, xa_nxt;
  axis_t ea4_r, xa4_r;
  t_t    ent4_r, ext4_r;
  logic  eneg4_r, xneg4_r;

  // ties: x only when strictly ahead of y and z; z wins a tie with x, y a tie with either
  always_comb begin
    if (te[0] > te[1]) ea_nxt = (te[0] > te[2]) ? AXIS_X : AXIS_Z;
    else               ea_nxt = (te[2] > te[1]) ? AXIS_Z : AXIS_Y;
    if (tx[0] < tx[1]) xa_nxt = (tx[0] < tx[2]) ? AXIS_X : AXIS_Z;
    else               xa_nxt = (tx[2] < tx[1]) ? AXIS_Z : AXIS_Y;
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      ea4_r   <= ea_nxt;
      xa4_r   <= xa_nxt;
      ent4_r  <= te[ea_nxt];
      ext4_r  <= tx[xa_nxt];
      eneg4_r <= dneg[ea_nxt];
      xneg4_r <= dneg[xa_nxt];
    end
  end

  // ------------------------------------------------- stage 5: clamp and test
  t_t    tl5, tu5;
  logic  eon_nxt, xon_nxt, hit_nxt;
  q_t    ent_c, ext_c;
  logic  hit5_r, eon5_r, xon5_r, eneg5_r, xneg5_r;
  axis_t ea5_r, xa5_r;
  q_t    ent5_r, ext5_r;

  assign tl5 = t_t'(ray_r[4].tl);
  assign tu5 = t_t'(ray_r[4].tu);

  always_comb begin
    eon_nxt = !(ent4_r < tl5);
    xon_nxt = !(ext4_r > tu5);
    ent_c   = eon_nxt ? ent4_r[31:0] : ray_r[4].tl;
    ext_c   = xon_nxt ? ext4_r[31:0] : ray_r[4].tu;
    hit_nxt = !((ent4_r > ext4_r) || (ext4_r < tl5) || (eon_nxt && (ent4_r > tu5))
                || (ent_c > ext_c));
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      hit5_r  <= hit_nxt;
      ent5_r  <= ent_c;
      ext5_r  <= ext_c;
      ea5_r   <= ea4_r;
      xa5_r   <= xa4_r;
      eon5_r  <= eon_nxt;
      xon5_r  <= xon_nxt;
      eneg5_r <= eon_nxt && eneg4_r;
      xneg5_r <= xon_nxt && xneg4_r;
    end
  end

  // ------------------------------------------------- stage 6: entry point products
  logic signed [63:0] prod6_r [3];
  logic               hit6_r, eon6_r, xon6_r, eneg6_r, xneg6_r;
  axis_t              ea6_r, xa6_r;
  q_t                 ent6_r, ext6_r;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      for (int k = 0; k < 3; k++) begin
        prod6_r[k] <= ray_r[5].dir[k] * ent5_r;
      end
      hit6_r  <= hit5_r;
      ent6_r  <= ent5_r;
      ext6_r  <= ext5_r;
      ea6_r   <= ea5_r;
      xa6_r   <= xa5_r;
      eon6_r  <= eon5_r;
      xon6_r  <= xon5_r;
      eneg6_r <= eneg5_r;
      xneg6_r <= xneg5_r;
    end
  end

  // ------------------------------------------------- stage 7: point and output
  logic signed [PW2:0] sum [3];
  q_t                  pt_nxt [3];
  q_t                  pt7_r [3];
  logic                hit7_r, eon7_r, xon7_r, eneg7_r, xneg7_r;
  axis_t               ea7_r, xa7_r;
  q_t                  ent7_r, ext7_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = (PW2 + 1)'(prod6_r[k] >>> FRAC_BITS) + (PW2 + 1)'(ray_r[6].org[k]);
      if ((&sum[k][PW2:31]) || !(|sum[k][PW2:31])) pt_nxt[k] = sum[k][31:0];
      else pt_nxt[k] = sum[k][PW2] ? Q_MIN : Q_MAX;
    end
  end

  // a miss reports zero in every field
  always_ff @(posedge clk) begin
    if (adv[7]) begin
      hit7_r  <= hit6_r;
      ent7_r  <= hit6_r ? ent6_r : '0;
      ext7_r  <= hit6_r ? ext6_r : '0;
      ea7_r   <= hit6_r ? ea6_r : AXIS_X;
      xa7_r   <= hit6_r ? xa6_r : AXIS_X;
      eon7_r  <= hit6_r && eon6_r;
      xon7_r  <= hit6_r && xon6_r;
      eneg7_r <= hit6_r && eneg6_r;
      xneg7_r <= hit6_r && xneg6_r;
      for (int k = 0; k < 3; k++) begin
        pt7_r[k] <= hit6_r ? pt_nxt[k] : '0;
      end
    end
  end

  assign out_res.valid          = vld_r[NSTG];
  assign out_res.hit            = hit7_r;
  assign out_res.t_entry        = ent7_r;
  assign out_res.t_exit         = ext7_r;
  assign out_res.entry_axis     = ea7_r;
  assign out_res.entry_on_face  = eon7_r;
  assign out_res.entry_negative = eneg7_r;
  assign out_res.exit_axis      = xa7_r;
  assign out_res.exit_on_face   = xon7_r;
  assign out_res.exit_negative  = xneg7_r;
  assign out_res.entry_point_x  = pt7_r[0];
  assign out_res.entry_point_y  = pt7_r[1];
  assign out_res.entry_point_z  = pt7_r[2];

  // ------------------------------------------------- checks
  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.hit |-> out_res.t_entry <= out_res.t_exit)
    else $error("hit record with entry after exit");

  a_neg_on_face: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && (out_res.entry_negative || out_res.exit_negative) |->
      (out_res.entry_on_face || !out_res.entry_negative) &&
      (out_res.exit_on_face || !out_res.exit_negative))
    else $error("negative flag without face");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.hit |->
      out_res.t_entry == '0 && out_res.t_exit == '0 && !out_res.entry_on_face &&
      !out_res.exit_on_face && out_res.entry_point_x == '0)
    else $error("miss record carries data");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] && !adv[5] |=> vld_r[4] && $stable(ent4_r) && $stable(ext4_r))
    else $error("stalled stage lost its beat");

  a_clamp_lower: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5] && hit5_r |-> ent5_r >= ray_r[5].tl && ext5_r <= ray_r[5].tu)
    else $error("clamped interval outside ray interval");

endmodule

@@ sim/ray_box_slab_intersect_tb.sv @@
// ray_box_slab_intersect_tb: self-checking bench for the fixed-point ray / box slab test.
// Needs rbs_pkg, rbs_ray_if, rbs_hit_if and the ray_box_slab_intersect rtl.
// Rays go in under random gaps and stalls; each record is checked against a local predictor.
`timescale 1ns / 1ps

module ray_box_slab_intersect_tb;
  import rbs_pkg::*;

  localparam int     FRAC        = FRAC_BITS_DEF;
  localparam int     COORD       = COORD_BITS_DEF;
  localparam int     PHASE_RAYS  = 136;
  localparam int     HOLD_CYCLES = 80;
  localparam int     PIPE_DEPTH  = 7;
  localparam longint ONE_L       = longint'(1) << FRAC;
  localparam longint T_UNBOUNDED = longint'(1) << 40;
  localparam longint PROD_CAP    = longint'(1) << 36;

  typedef struct {
    q_t org[3];
    q_t dir[3];
    q_t inv[3];
    q_t t_lo;
    q_t t_hi;
  } ray_t;

  typedef struct {
    logic       hit;
    q_t         t_entry;
    q_t         t_exit;
    logic [1:0] entry_axis;
    logic       entry_on_face;
    logic       entry_negative;
    logic [1:0] exit_axis;
    logic       exit_on_face;
    logic       exit_negative;
    q_t         entry_point[3];
  } hit_rec_t;

  class slab_scoreboard;
    coord_t   box_lo[3];
    coord_t   box_hi[3];
    hit_rec_t pending_hits[$];
    int       errors;

    function new();
      box_lo = '{BOX_MIN_RST, BOX_MIN_RST, BOX_MIN_RST};
      box_hi = '{BOX_MAX_RST, BOX_MAX_RST, BOX_MAX_RST};
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, coord_t v);
      case (idx)
        REG_BOX_MIN_X: box_lo[0] = v;
        REG_BOX_MIN_Y: box_lo[1] = v;
        REG_BOX_MIN_Z: box_lo[2] = v;
        REG_BOX_MAX_X: box_hi[0] = v;
        REG_BOX_MAX_Y: box_hi[1] = v;
        REG_BOX_MAX_Z: box_hi[2] = v;
        default: ;
      endcase
    endfunction

    function longint sat32(longint v);
      if (v > longint'(Q_MAX)) return longint'(Q_MAX);
      if (v < longint'(Q_MIN)) return longint'(Q_MIN);
      return v;
    endfunction

    // floor(a*b / 2^FRAC), clamped to the product cap
    function longint fixmul(longint a, longint b);
      logic signed [127:0] p;
      p = a;
      p = p * b;
      p = p >>> FRAC;
      if (p > PROD_CAP) return PROD_CAP;
      if (p < -PROD_CAP) return -PROD_CAP;
      return longint'(p);
    endfunction

    function hit_rec_t slab_test(ray_t r);
      longint     org[3], dir[3], inv[3], te[3], tx[3];
      longint     fe, fx, ent, ext, tl, tu;
      logic [1:0] ea, xa;
      bit         dneg[3];
      bit         eon, xon;
      hit_rec_t   h;
      h  = '{default: '0};
      tl = r.t_lo;
      tu = r.t_hi;
      for (int k = 0; k < 3; k++) begin
        org[k]  = r.org[k];
        dir[k]  = r.dir[k];
        inv[k]  = r.inv[k];
        dneg[k] = dir[k] < 0;
        // a flat axis leaves the ray unconstrained
        if (dir[k] == 0) begin
          te[k] = -T_UNBOUNDED;
          tx[k] = T_UNBOUNDED;
        end else begin
          fe = dneg[k] ? longint'(box_hi[k]) : longint'(box_lo[k]);
          fx = dneg[k] ? longint'(box_lo[k]) : longint'(box_hi[k]);
          te[k] = sat32(fixmul(fe * ONE_L - org[k], inv[k]));
          tx[k] = sat32(fixmul(fx * ONE_L - org[k], inv[k]));
        end
      end
      // ties fall to z over x, and to y over both x and z
      if (te[0] > te[1]) ea = (te[0] > te[2]) ? AXIS_X : AXIS_Z;
      else ea = (te[2] > te[1]) ? AXIS_Z : AXIS_Y;
      if (tx[0] < tx[1]) xa = (tx[0] < tx[2]) ? AXIS_X : AXIS_Z;
      else xa = (tx[2] < tx[1]) ? AXIS_Z : AXIS_Y;
      ent = te[ea];
      ext = tx[xa];
      if (ent > ext || ext < tl) return h;
      if (ent < tl) begin
        ent = tl;
        eon = 1'b0;
      end else if (ent > tu) begin
        return h;
      end else begin
        eon = 1'b1;
      end
      if (ext > tu) begin
        ext = tu;
        xon = 1'b0;
      end else begin
        xon = 1'b1;
      end
      if (ent > ext) return h;
      h.hit            = 1'b1;
      h.t_entry        = q_t'(ent);
      h.t_exit         = q_t'(ext);
      h.entry_axis     = ea;
      h.entry_on_face  = eon;
      h.entry_negative = eon && dneg[ea];
      h.exit_axis      = xa;
      h.exit_on_face   = xon;
      h.exit_negative  = xon && dneg[xa];
      for (int k = 0; k < 3; k++)
        h.entry_point[k] = q_t'(sat32(org[k] + fixmul(dir[k], ent)));
      return h;
    endfunction

    function void note_ray(ray_t r);
      pending_hits = {pending_hits, slab_test(r)};
    endfunction

    function void check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_hit(hit_rec_t got);
      hit_rec_t want;
      if (pending_hits.size() == 0) begin
        $error("result beat with no ray outstanding");
        errors++;
        return;
      end
      want = pending_hits.pop_front();
      check_field("hit", want.hit, got.hit);
      check_field("t_entry", want.t_entry, got.t_entry);
      check_field("t_exit", want.t_exit, got.t_exit);
      check_field("entry_axis", want.entry_axis, got.entry_axis);
      check_field("entry_on_face", want.entry_on_face, got.entry_on_face);
      check_field("entry_negative", want.entry_negative, got.entry_negative);
      check_field("exit_axis", want.exit_axis, got.exit_axis);
      check_field("exit_on_face", want.exit_on_face, got.exit_on_face);
      check_field("exit_negative", want.exit_negative, got.exit_negative);
      check_field("entry_point_x", want.entry_point[0], got.entry_point[0]);
      check_field("entry_point_y", want.entry_point[1], got.entry_point[1]);
      check_field("entry_point_z", want.entry_point[2], got.entry_point[2]);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  rbs_ray_if ray_ch ();
  rbs_hit_if res_ch ();

  slab_scoreboard sb;
  int ray_gap_pct;
  int res_stall_pct;
  bit hold_req;
  int hold_left;

  ray_box_slab_intersect #(
    .FRAC_BITS  (FRAC),
    .COORD_BITS (COORD)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ray    (ray_ch),
    .out_res   (res_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: check the beat taken at this edge, then pick ready for the next
  always @(posedge clk) begin : res_sink
    hit_rec_t got;
    if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got.hit            = res_ch.hit;
      got.t_entry        = res_ch.t_entry;
      got.t_exit         = res_ch.t_exit;
      got.entry_axis     = res_ch.entry_axis;
      got.entry_on_face  = res_ch.entry_on_face;
      got.entry_negative = res_ch.entry_negative;
      got.exit_axis      = res_ch.exit_axis;
      got.exit_on_face   = res_ch.exit_on_face;
      got.exit_negative  = res_ch.exit_negative;
      got.entry_point[0] = res_ch.entry_point_x;
      got.entry_point[1] = res_ch.entry_point_y;
      got.entry_point[2] = res_ch.entry_point_z;
      sb.check_hit(got);
    end
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= res_stall_pct);
    end
  end

  initial begin
    #4_000_000;
    $display("ray_box_slab_intersect_tb: done, errors");
    $finish;
  end

  function automatic q_t qu(int u);
    return q_t'(longint'(u) * ONE_L);
  endfunction

  function automatic ray_t beam(q_t ox, oy, oz, dx, dy, dz, ix, iy, iz, lo, hi);
    ray_t r;
    r.org  = '{ox, oy, oz};
    r.dir  = '{dx, dy, dz};
    r.inv  = '{ix, iy, iz};
    r.t_lo = lo;
    r.t_hi = hi;
    return r;
  endfunction

  // mostly rays aimed through a point of the box, the rest broken or pure noise
  function automatic ray_t random_ray();
    ray_t   r;
    longint lo_q, hi_q, span, pnt, d, t0, tl, tu, tmp;
    int     pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      for (int k = 0; k < 3; k++) begin
        r.org[k] = $urandom;
        r.dir[k] = $urandom;
        r.inv[k] = $urandom;
      end
      r.t_lo = $urandom;
      r.t_hi = $urandom;
      return r;
    end
    t0 = $urandom_range(0, 64 * 65536);
    for (int k = 0; k < 3; k++) begin
      lo_q = longint'(sb.box_lo[k]) * ONE_L;
      hi_q = longint'(sb.box_hi[k]) * ONE_L;
      if (lo_q > hi_q) begin
        tmp  = lo_q;
        lo_q = hi_q;
        hi_q = tmp;
      end
      span = hi_q - lo_q;
      pnt  = lo_q + longint'({$urandom, $urandom} % (span + 1));
      if ($urandom_range(9) == 0) begin
        d        = 0;
        r.inv[k] = $urandom;
      end else begin
        d = $urandom_range(1024, 1 << 20);
        if ($urandom_range(1)) d = -d;
        r.inv[k] = q_t'((longint'(1) << (2 * FRAC)) / d);
      end
      r.dir[k] = q_t'(d);
      r.org[k] = q_t'(sb.sat32(pnt - ((d * t0) >>> FRAC)));
    end
    case ($urandom_range(3))
      0: tl = 0;
      1: tl = -longint'($urandom_range(0, 16 * 65536));
      2: tl = $urandom_range(0, t0);
      default: tl = longint'(Q_MIN);
    endcase
    case ($urandom_range(3))
      0: tu = longint'(Q_MAX);
      1: tu = t0 + $urandom_range(0, 64 * 65536);
      2: tu = $urandom_range(0, 128 * 65536);
      default: tu = tl + $urandom_range(0, 8 * 65536);
    endcase
    r.t_lo = q_t'(tl);
    r.t_hi = q_t'(sb.sat32(tu));
    if (pick < 30) begin
      case ($urandom_range(3))
        0: r.inv[$urandom_range(2)] = $urandom;
        1: r.dir[$urandom_range(2)] = $urandom;
        2: r.t_lo = $urandom;
        default: r.org[$urandom_range(2)] = $urandom;
      endcase
    end
    return r;
  endfunction

  task automatic send_ray(input ray_t r);
    while ($urandom_range(99) < ray_gap_pct) begin
      ray_ch.valid <= 1'b0;
      @(posedge clk);
    end
    ray_ch.valid       <= 1'b1;
    ray_ch.origin_x    <= r.org[0];
    ray_ch.origin_y    <= r.org[1];
    ray_ch.origin_z    <= r.org[2];
    ray_ch.direction_x <= r.dir[0];
    ray_ch.direction_y <= r.dir[1];
    ray_ch.direction_z <= r.dir[2];
    ray_ch.inverse_x   <= r.inv[0];
    ray_ch.inverse_y   <= r.inv[1];
    ray_ch.inverse_z   <= r.inv[2];
    ray_ch.t_lower     <= r.t_lo;
    ray_ch.t_upper     <= r.t_hi;
    do @(posedge clk); while (ray_ch.ready !== 1'b1);
    sb.note_ray(r);
  endtask

  task automatic wait_all_hits();
    ray_ch.valid <= 1'b0;
    while (sb.pending_hits.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input coord_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_box(input coord_t mn[3], input coord_t mx[3]);
    write_reg(REG_BOX_MIN_X, mn[0]);
    write_reg(REG_BOX_MIN_Y, mn[1]);
    write_reg(REG_BOX_MIN_Z, mn[2]);
    write_reg(REG_BOX_MAX_X, mx[0]);
    write_reg(REG_BOX_MAX_Y, mx[1]);
    write_reg(REG_BOX_MAX_Z, mx[2]);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    coord_t mn[3];
    coord_t mx[3];
    sb                 = new();
    ray_gap_pct        = 0;
    res_stall_pct      = 0;
    hold_req           = 1'b0;
    hold_left          = 0;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_BOX_MIN_X;
    cfg_wdata          = '0;
    res_ch.ready       = 1'b0;
    ray_ch.valid       = 1'b0;
    ray_ch.origin_x    = '0;
    ray_ch.origin_y    = '0;
    ray_ch.origin_z    = '0;
    ray_ch.direction_x = '0;
    ray_ch.direction_y = '0;
    ray_ch.direction_z = '0;
    ray_ch.inverse_x   = '0;
    ray_ch.inverse_y   = '0;
    ray_ch.inverse_z   = '0;
    ray_ch.t_lower     = '0;
    ray_ch.t_upper     = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed rays against the reset box, one face each way first
    send_ray(beam(qu(-16), qu(128), qu(128), qu(1), 0, 0, qu(1), 32'sh1234, -7, 0, Q_MAX));
    send_ray(beam(qu(300), qu(100), qu(50), qu(-1), 0, 0, qu(-1), 0, 0, 0, Q_MAX));
    send_ray(beam(qu(10), qu(-5), qu(20), 0, qu(2), 0, 0, 32'sh8000, 0, 0, Q_MAX));
    send_ray(beam(qu(10), qu(400), qu(20), 0, qu(-1), 0, 0, qu(-1), 0, 0, Q_MAX));
    send_ray(beam(qu(200), qu(200), qu(-1), 0, 0, qu(1), 0, 0, qu(1), 0, Q_MAX));
    send_ray(beam(qu(1), qu(1), qu(1000), 0, 0, qu(-4), 0, 0, -32'sh4000, 0, Q_MAX));
    // flat ray, inside and far outside
    send_ray(beam(qu(5), qu(5), qu(5), 0, 0, 0, qu(3), qu(-3), Q_MAX, 0, qu(10)));
    send_ray(beam(qu(-500), qu(999), qu(-3), 0, 0, 0, 0, 0, 0, qu(-3), qu(7)));
    // origin inside: entry clamped to t_lower; then exit clamped to t_upper
    send_ray(beam(qu(128), qu(128), qu(128), qu(1), 32'sh8000, 32'sh4000,
                  qu(1), qu(2), qu(4), 0, Q_MAX));
    send_ray(beam(qu(-16), qu(128), qu(128), qu(1), 0, 0, qu(1), 0, 0, 0, qu(100)));
    // misses: beside, empty interval, exit before t_lower, entry after t_upper
    send_ray(beam(qu(-16), qu(300), qu(128), qu(1), qu(1), 0, qu(1), qu(1), 0, 0, Q_MAX));
    send_ray(beam(qu(-16), qu(128), qu(128), qu(1), 0, 0, qu(1), 0, 0, qu(50), qu(20)));
    send_ray(beam(qu(-16), qu(128), qu(128), qu(1), 0, 0, qu(1), 0, 0, qu(300), Q_MAX));
    send_ray(beam(qu(-16), qu(128), qu(128), qu(1), 0, 0, qu(1), 0, 0, 0, qu(10)));
    // tie orders
    send_ray(beam(qu(-10), qu(-10), qu(-10), qu(1), qu(1), qu(1),
                  qu(1), qu(1), qu(1), 0, Q_MAX));
    send_ray(beam(qu(-10), qu(128), qu(-10), qu(1), 0, qu(1), qu(1), 0, qu(1), 0, Q_MAX));
    send_ray(beam(qu(-10), qu(-10), qu(128), qu(1), qu(1), 0, qu(1), qu(1), 0, 0, Q_MAX));
    // inverse with the wrong sign
    send_ray(beam(qu(-16), qu(128), qu(128), qu(1), 0, 0, qu(-1), 0, 0, 0, Q_MAX));
    // field extremes and saturating products
    send_ray(beam(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, -1, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX));
    send_ray(beam(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    send_ray(beam(qu(-16), qu(128), qu(128), 1, 0, 0, Q_MAX, 0, 0, Q_MIN, Q_MAX));
    send_ray(beam(qu(300), qu(128), qu(128), qu(1), 0, 0, qu(1), 0, 0, Q_MIN, Q_MAX));
    send_ray(beam(qu(-32767), 0, 0, Q_MAX, 0, 0, 8, 0, 0, Q_MIN, Q_MAX));
    wait_all_hits();

    for (int p = 0; p < 9; p++) begin
      case (p % 4)
        0: begin ray_gap_pct = 0;  res_stall_pct = 0;  end
        1: begin ray_gap_pct = 49; res_stall_pct = 0;  end
        2: begin ray_gap_pct = 0;  res_stall_pct = 49; end
        default: begin ray_gap_pct = 21; res_stall_pct = 21; end
      endcase
      if (p != 0) begin
        for (int k = 0; k < 3; k++) begin
          case (p)
            3: begin
              mn[k] = -16'sd32768;
              mx[k] = 16'sd32767;
            end
            4: begin
              // x slab turned inside out, the rest small
              mn[k] = (k == 0) ? 16'sd50 : coord_t'($urandom_range(0, 128) - 64);
              mx[k] = (k == 0) ? -16'sd50 : mn[k] + coord_t'($urandom_range(0, 64));
            end
            5: begin
              mn[k] = coord_t'($urandom_range(0, 128) - 64);
              mx[k] = mn[k];
            end
            6: begin
              mn[k] = coord_t'($urandom);
              mx[k] = coord_t'($urandom);
            end
            8: begin
              mn[k] = 16'sd32767;
              mx[k] = 16'sd32767;
            end
            default: begin
              mn[k] = coord_t'($urandom_range(0, 128) - 64);
              mx[k] = mn[k] + coord_t'($urandom_range(0, 64));
            end
          endcase
        end
        set_box(mn, mx);
      end
      for (int i = 0; i < PHASE_RAYS; i++) begin
        // long result hold-off while rays keep coming, so the pipe backs up
        if (i == 30 && (p == 0 || p == 4)) hold_req = 1'b1;
        if (i == 60 && p == 2) wait_all_hits();
        send_ray(random_ray());
      end
      wait_all_hits();
    end

    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ray_box_slab_intersect_tb: done, clean");
    end else begin
      $display("ray_box_slab_intersect_tb: done, errors");
    end
    $finish;
  end

endmodule
